[hw/rtl/nearest_ray_segment_hit_core_macros.svh]
// Assertion macros for the nearest ray segment hit core
`ifndef NEAREST_RAY_SEGMENT_HIT_CORE_MACROS_SVH
`define NEAREST_RAY_SEGMENT_HIT_CORE_MACROS_SVH
// Check that an implication holds at every clock edge outside reset
`define NRSH_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");
// Check a property that must hold also during reset
`define NRSH_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`endif

[hw/rtl/nrsh_pkg.sv]
// Package: payload types and fixed widths of the nearest ray segment hit core
`timescale 1ns / 1ps
package nrsh_pkg;
	localparam int unsigned CW = 16;       // coordinate width
	localparam int unsigned PW = 64;       // wrapped product width
	localparam int unsigned TW = 36;       // stored t width

	typedef struct packed {
		logic signed [CW-1:0] ray_start_x;
		logic signed [CW-1:0] ray_start_y;
		logic signed [CW-1:0] ray_end_x;
		logic signed [CW-1:0] ray_end_y;
		logic signed [CW-1:0] wall_a_x;
		logic signed [CW-1:0] wall_a_y;
		logic signed [CW-1:0] wall_b_x;
		logic signed [CW-1:0] wall_b_y;
		logic                 wall_present;
		logic                 is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [CW-1:0] hit_x;
		logic signed [CW-1:0] hit_y;
	} out_item_t;

	// Divider control between sequencer and divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctrl_t;
endpackage

[hw/rtl/nearest_ray_segment_hit_core.sv]
// Top level: sequencer over a shared multiplier and a serial divider
`timescale 1ns / 1ps
// A segment item holds the input stalled through seven multiplier steps for den,
// t and u, three for the nearer-hit compare and one test, so no new item is taken
// until the sequencer is back in S_IDLE; an item without a segment that is not last
// is taken back to back. A last item with a held hit adds the multiplier steps
// S_H0 to S_H3 and two 64-step divides before the result is offered; with no held
// hit the result is offered from S_H0. Reset clears the sequencer, the held hit
// and the output valid.
module nearest_ray_segment_hit_core
	import nrsh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	localparam int unsigned LW   = 2 * TW;  // width of the cross-multiplied t compare
	localparam int unsigned HALF = TW / 2;  // split point of a 36-bit t operand
	localparam int unsigned MBW  = TW + 1;  // multiplier b operand width

	typedef enum logic [4:0] {
		S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
		S_C0, S_C1, S_C2, S_TEST,
		S_H0, S_H1, S_H2, S_H3, S_DX, S_DY, S_OUT
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic signed [PW-1:0] acc_q, den_q, tn_q, un_q;
	logic [TW-1:0] bt_n_q, bt_d_q;
	logic found_q;
	logic signed [31:0] ma;
	logic signed [MBW-1:0] mb;
	logic signed [PW-1:0] mp;
	logic signed [PW-1:0] cx_q;
	logic div_start;
	div_ctrl_t dctl;
	logic signed [PW-1:0] dquo, dnum;
	logic signed [CW-1:0] hx_q;
	logic [LW-1:0] lhs_q, rhs_q;

	// Sign-extended differences from the held item, wrapped to 32 bits
	logic signed [31:0] rdx, rdy, sdx, sdy, qx, qy, sx, sy;
	assign sx  = 32'(item_q.ray_start_x);
	assign sy  = 32'(item_q.ray_start_y);
	assign rdx = 32'(item_q.ray_end_x) - sx;
	assign rdy = 32'(item_q.ray_end_y) - sy;
	assign sdx = 32'(item_q.wall_b_x) - 32'(item_q.wall_a_x);
	assign sdy = 32'(item_q.wall_b_y) - 32'(item_q.wall_a_y);
	assign qx  = 32'(item_q.wall_a_x) - sx;
	assign qy  = 32'(item_q.wall_a_y) - sy;

	// Hit test on normalised den, tn, un
	logic signed [PW-1:0] nden, ntn, nun;
	logic ok, nearer;
	assign nden = den_q[PW-1] ? -den_q : den_q;
	assign ntn  = den_q[PW-1] ? -tn_q  : tn_q;
	assign nun  = den_q[PW-1] ? -un_q  : un_q;
	assign ok   = (nden > 0) && (ntn >= 0) && (nun >= 0) && (nun <= nden);
	// Nearer when tn*bd < bn*den; each side is built from two half-width products,
	// the last one of the right side arriving in the test cycle itself
	assign nearer = !found_q || (lhs_q < rhs_q + LW'(mp));

	// Operand selection for the shared multiplier; the product is registered
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_M0: begin ma = rdx; mb = MBW'(sdy); end
			S_M1: begin ma = rdy; mb = MBW'(sdx); end
			S_M2: begin ma = qx;  mb = MBW'(sdy); end
			S_M3: begin ma = qy;  mb = MBW'(sdx); end
			S_M4: begin ma = qx;  mb = MBW'(rdy); end
			S_M5: begin ma = qy;  mb = MBW'(rdx); end
			S_M6: begin
				ma = 32'(ntn[TW-1:HALF]);
				mb = $signed({1'b0, bt_d_q});
			end
			S_C0: begin
				ma = 32'(ntn[HALF-1:0]);
				mb = $signed({1'b0, bt_d_q});
			end
			S_C1: begin
				ma = 32'(bt_n_q[TW-1:HALF]);
				mb = $signed({1'b0, nden[TW-1:0]});
			end
			S_C2: begin
				ma = 32'(bt_n_q[HALF-1:0]);
				mb = $signed({1'b0, nden[TW-1:0]});
			end
			S_H0: begin ma = sx;  mb = $signed({1'b0, bt_d_q}); end
			S_H1: begin ma = rdx; mb = $signed({1'b0, bt_n_q}); end
			S_H2: begin ma = sy;  mb = $signed({1'b0, bt_d_q}); end
			// hold the y operands while the x divide runs so the product stays put
			S_H3, S_DX: begin ma = rdy; mb = $signed({1'b0, bt_n_q}); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	nrsh_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	// The x divide starts in S_H3, the y divide in S_DY
	assign dnum = (state_q == S_H3) ? cx_q : acc_q;

	nrsh_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .num(dnum),
		.dvs($signed({{(PW-TW){1'b0}}, bt_d_q})), .ctrl(dctl), .quo(dquo));

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			found_q   <= 1'b0;
			out_valid <= 1'b0;
			div_start <= 1'b0;
			bt_n_q    <= '0;
			bt_d_q    <= '0;
		end else begin
			div_start <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					item_q  <= in_item;
					state_q <= in_item.wall_present ? S_M0 :
						(in_item.is_last ? S_H0 : S_IDLE);
				end
				S_M0: state_q <= S_M1;
				S_M1: begin acc_q <= mp; state_q <= S_M2; end
				S_M2: begin den_q <= acc_q - mp; state_q <= S_M3; end
				S_M3: begin acc_q <= mp; state_q <= S_M4; end
				S_M4: begin tn_q <= acc_q - mp; state_q <= S_M5; end
				S_M5: begin acc_q <= mp; state_q <= S_M6; end
				S_M6: begin un_q <= acc_q - mp; state_q <= S_C0; end
				S_C0: begin lhs_q <= LW'(mp) << HALF; state_q <= S_C1; end
				S_C1: begin lhs_q <= lhs_q + LW'(mp); state_q <= S_C2; end
				S_C2: begin rhs_q <= LW'(mp) << HALF; state_q <= S_TEST; end
				S_TEST: begin
					if (ok && nearer) begin
						bt_n_q  <= ntn[TW-1:0];
						bt_d_q  <= nden[TW-1:0];
						found_q <= 1'b1;
					end
					state_q <= item_q.is_last ? S_H0 : S_IDLE;
				end
				S_H0: begin
					if (!found_q) begin
						hx_q      <= '1;
						out_item  <= '{hit_x: '1, hit_y: '1};
						out_valid <= 1'b1;
						state_q   <= S_OUT;
					end else state_q <= S_H1;
				end
				S_H1: begin acc_q <= mp; state_q <= S_H2; end
				S_H2: begin
					// x numerator ready; start the x divide
					cx_q      <= acc_q + mp;
					div_start <= 1'b1;
					state_q   <= S_H3;
				end
				S_H3: begin acc_q <= mp; state_q <= S_DX; end
				S_DX: begin
					if (dctl.done) begin
						hx_q      <= dquo[CW-1:0];
						acc_q     <= acc_q + mp;
						div_start <= 1'b1;
						state_q   <= S_DY;
					end
				end
				S_DY: begin
					if (dctl.done) begin
						out_item  <= '{hit_x: hx_q, hit_y: dquo[CW-1:0]};
						out_valid <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						// drop the result and clear the held hit
						out_valid <= 1'b0;
						found_q   <= 1'b0;
						bt_n_q    <= '0;
						bt_d_q    <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
	// The ry*n product stays in mp through S_DX because its operands are held there
endmodule

[hw/rtl/nrsh_div.sv]
// Signed restoring divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
module nrsh_div
	import nrsh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [PW-1:0] num,
	input  logic signed [PW-1:0] dvs,
	output div_ctrl_t            ctrl,
	output logic signed [PW-1:0] quo
);
	localparam int unsigned CNTW = $clog2(PW + 1);

	logic [PW-1:0]   rem_q, quo_q, dvs_q;
	logic            neg_q, busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [PW:0]     trial;
	logic [PW-1:0]   shifted;

	assign shifted = {rem_q[PW-2:0], quo_q[PW-1]};
	assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// hold magnitudes, remember sign of the quotient
				rem_q  <= '0;
				quo_q  <= num[PW-1] ? (~num + 1'b1) : num;
				dvs_q  <= dvs[PW-1] ? (~dvs + 1'b1) : dvs;
				neg_q  <= num[PW-1] ^ dvs[PW-1];
				cnt_q  <= CNTW'(PW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!trial[PW]) begin
					rem_q <= trial[PW-1:0];
					quo_q <= {quo_q[PW-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[PW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quo        = neg_q ? $signed(~quo_q + 1'b1) : $signed(quo_q);
	assign ctrl.start = start;
	assign ctrl.busy  = busy_q;
	assign ctrl.done  = done_q;
endmodule

[hw/rtl/nrsh_mul.sv]
// Shared 32x37 signed multiplier with a registered product
`timescale 1ns / 1ps
module nrsh_mul
	import nrsh_pkg::*;
(
	input  logic                 clk,
	input  logic signed [31:0]   a,
	input  logic signed [TW:0]   b,
	output logic signed [PW-1:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

[hw/rtl/nrsh_checker.sv]
// Port checker for the nearest ray segment hit core, with its bind
`timescale 1ns / 1ps
`include "nearest_ray_segment_hit_core_macros.svh"
module nrsh_checker
	import nrsh_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);
	`NRSH_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_item))
	`NRSH_ASSERT(a_busy_on_out, clk, arst_n, out_valid |-> in_stall)
	`NRSH_ASSERT(a_take_stalls, clk, arst_n, in_valid && !in_stall |=> in_stall || !out_valid)
	`NRSH_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid)
endmodule

bind nearest_ray_segment_hit_core nrsh_checker u_nrsh_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
